@@ rtl/http_response_framer_top_macros.svh @@
// ----------------------------------------------------------------------------
// http_response_framer_top_macros: assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_FRAMER_TOP_MACROS_SVH
`define HTTP_RESPONSE_FRAMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// clocked property, disabled during reset
`define HRF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);
// clocked property, checked in reset too
`define HRF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);
`else
`define HRF_ASSERT(label, clk, rst, prop, msg)
`define HRF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/hrf_pkg.sv @@
// ----------------------------------------------------------------------------
// hrf_pkg: shared types and constants of the response framer
// Phase codes, match state struct and the header prefix pattern.
// ----------------------------------------------------------------------------
package hrf_pkg;

  // framer phases
  localparam logic [1:0] PH_HEADERS = 2'd0;
  localparam logic [1:0] PH_DIGITS  = 2'd1;
  localparam logic [1:0] PH_KNOWN   = 2'd2;
  localparam logic [1:0] PH_BODY    = 2'd3;

  localparam logic [4:0] HDR_LEN = 5'd18;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic [1:0] phase;
    logic [4:0] hdr_pos;
    logic [1:0] blank_pos;
  } hrf_ctl_t;

  // CR LF "Content-Length: "
  function automatic logic [7:0] hdr_char(input logic [4:0] pos);
    logic [7:0] ch;
    unique case (pos)
      5'd0:    ch = CH_CR;
      5'd1:    ch = CH_LF;
      5'd2:    ch = 8'h43;  // C
      5'd3:    ch = 8'h6f;  // o
      5'd4:    ch = 8'h6e;  // n
      5'd5:    ch = 8'h74;  // t
      5'd6:    ch = 8'h65;  // e
      5'd7:    ch = 8'h6e;  // n
      5'd8:    ch = 8'h74;  // t
      5'd9:    ch = 8'h2d;  // -
      5'd10:   ch = 8'h4c;  // L
      5'd11:   ch = 8'h65;  // e
      5'd12:   ch = 8'h6e;  // n
      5'd13:   ch = 8'h67;  // g
      5'd14:   ch = 8'h74;  // t
      5'd15:   ch = 8'h68;  // h
      5'd16:   ch = 8'h3a;  // :
      5'd17:   ch = 8'h20;  // space
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/http_response_framer_top.sv @@
// ----------------------------------------------------------------------------
// http_response_framer_top: HTTP response message framer
// Passes a response byte stream through and flags the byte that ends each
// message, using the Content-Length header and the blank line.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | in_valid / in_stall  | data_byte
//  output   | out_valid / out_stall| out_byte, message_end
//
//  one word per clock while the output is not stalled; each word passes the
//  input register, then the result register; the state loop closes in hrf_step
//  rst (synchronous) empties both registers and clears the framer state
//  in_stall rises only when the input register holds a word and the result
//  register is full and stalled; it depends on out_stall, never on in_valid
// ----------------------------------------------------------------------------
`include "http_response_framer_top_macros.svh"

module http_response_framer_top #(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       message_end
);
  import hrf_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_stall;
  logic       s1_fire;

  // framer state
  hrf_ctl_t               ctl;
  hrf_ctl_t               ctl_next;
  logic [LENGTH_BITS-1:0] body_remaining;
  logic [LENGTH_BITS-1:0] body_remaining_next;
  logic                   step_end;

  // the input word waits only while the result register cannot take it
  assign s1_stall = s1_valid && out_valid && out_stall;
  assign s1_fire  = s1_valid && !s1_stall;
  assign in_stall = s1_stall;

  hrf_step #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .data_byte          (s1_byte),
    .ctl                (ctl),
    .body_remaining     (body_remaining),
    .ctl_next           (ctl_next),
    .body_remaining_next(body_remaining_next),
    .message_end        (step_end)
  );

  // control: valid flags and framer state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      ctl            <= '0;
      body_remaining <= '0;
    end else begin
      if (!s1_stall) begin
        s1_valid <= in_valid;
      end
      if (s1_fire) begin
        out_valid      <= 1'b1;
        ctl            <= ctl_next;
        body_remaining <= body_remaining_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (!s1_stall) begin
      s1_byte <= data_byte;
    end
    if (s1_fire) begin
      out_byte    <= s1_byte;
      message_end <= step_end;
    end
  end

  // a finished message leaves the framer in its reset state
  `HRF_ASSERT(a_clear_after_end, clk, rst, (s1_fire && step_end) |=> (ctl == '0 && body_remaining == '0), "framer state not cleared after message end")
  // the body phase is only entered with a nonzero count
  `HRF_ASSERT(a_body_nonzero, clk, rst, (ctl.phase == PH_BODY) |-> (body_remaining != '0), "body phase with zero count")
  // header match position never runs past the prefix
  `HRF_ASSERT(a_hdr_pos_range, clk, rst, ctl.hdr_pos <= HDR_LEN, "header match position out of range")
  // back pressure only when both registers are full and the output stalls
  `HRF_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (s1_valid && out_valid && out_stall), "input stalled without a full, stalled output")

endmodule

@@ rtl/hrf_step.sv @@
// ----------------------------------------------------------------------------
// hrf_step: next-state logic of the response framer
// Header prefix match, length digit accumulation, blank line match and
// body countdown for one word.
// ----------------------------------------------------------------------------
module hrf_step #(
  parameter int LENGTH_BITS = 32
) (
  input  logic [7:0]             data_byte,
  input  hrf_pkg::hrf_ctl_t      ctl,
  input  logic [LENGTH_BITS-1:0] body_remaining,
  output hrf_pkg::hrf_ctl_t      ctl_next,
  output logic [LENGTH_BITS-1:0] body_remaining_next,
  output logic                   message_end
);
  import hrf_pkg::*;

  localparam int WIDE_BITS = LENGTH_BITS + 4;

  logic                   is_digit;
  logic [WIDE_BITS-1:0]   len_wide;
  logic [WIDE_BITS-1:0]   acc_wide;
  logic [LENGTH_BITS-1:0] acc_sat;
  logic                   check_blank;
  logic [7:0]             blank_char;
  logic [4:0]             hdr_pos_inc;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

  // len * 10 + digit, saturating
  assign len_wide = {4'b0, body_remaining};
  assign acc_wide = (len_wide << 3) + (len_wide << 1)
                  + {{(WIDE_BITS-4){1'b0}}, data_byte[3:0]};
  assign acc_sat  = (acc_wide[WIDE_BITS-1:LENGTH_BITS] != 4'd0) ?
                    {LENGTH_BITS{1'b1}} : acc_wide[LENGTH_BITS-1:0];

  assign blank_char  = ctl.blank_pos[0] ? CH_LF : CH_CR;
  assign hdr_pos_inc = ctl.hdr_pos + 5'd1;

  always_comb begin
    ctl_next            = ctl;
    body_remaining_next = body_remaining;
    message_end         = 1'b0;
    check_blank         = 1'b1;

    unique case (ctl.phase)
      PH_BODY: begin
        check_blank = 1'b0;
        if (body_remaining[LENGTH_BITS-1:1] == '0) begin
          message_end = 1'b1;
        end else begin
          body_remaining_next = body_remaining - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        end
      end
      PH_DIGITS: begin
        if (is_digit) begin
          body_remaining_next = acc_sat;
          check_blank         = 1'b0;
        end else begin
          ctl_next.phase = PH_KNOWN;
        end
      end
      PH_HEADERS: begin
        if ((ctl.hdr_pos < HDR_LEN) && (data_byte == hdr_char(ctl.hdr_pos))) begin
          ctl_next.hdr_pos = hdr_pos_inc;
          if (hdr_pos_inc == HDR_LEN) begin
            ctl_next.phase      = PH_DIGITS;
            body_remaining_next = '0;
          end
        end else begin
          ctl_next.hdr_pos = 5'd0;
        end
      end
      default: begin
        // length known, only the blank line matcher runs
      end
    endcase

    if (check_blank) begin
      if (data_byte == blank_char) begin
        if (ctl.blank_pos == 2'd3) begin
          ctl_next.blank_pos = 2'd0;
          if (body_remaining_next != '0) begin
            ctl_next.phase = PH_BODY;
          end else begin
            message_end = 1'b1;
          end
        end else begin
          ctl_next.blank_pos = ctl.blank_pos + 2'd1;
        end
      end else begin
        ctl_next.blank_pos = 2'd0;
      end
    end

    // end of message returns everything to reset
    if (message_end) begin
      ctl_next            = '0;
      body_remaining_next = '0;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the http response framer
// Streams response bytes into the framer under several idle and stall mixes,
// predicts each passed-through word and its end-of-message flag, and compares
// every accepted output word against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import hrf_pkg::*;

  localparam int LEN_BITS     = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  // CR LF "Content-Length: ", first byte in the top bits
  localparam logic [8*18-1:0] HDR_TEXT = {CH_CR, CH_LF, "Content-Length: "};

  typedef struct packed {
    logic [7:0] out_byte;
    logic       message_end;
  } frame_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       message_end;

  // own copy of the framer state
  logic [1:0]          fr_phase;
  logic [LEN_BITS-1:0] fr_remaining;
  logic [4:0]          fr_hdr_pos;
  logic [1:0]          fr_blank_pos;

  frame_word_t frames_due[$];   // predicted words not yet seen at the output
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          idle_pct = 0;      // sender idle chance, percent per cycle
  int          stall_pct = 0;     // receiver stall chance, percent per cycle

  http_response_framer_top #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .message_end(message_end)
  );

  always #5 clk = ~clk;

  // run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // clear the predicted framer state, as after reset or a finished message
  function automatic void clear_framer();
    fr_phase     = PH_HEADERS;
    fr_remaining = '0;
    fr_hdr_pos   = '0;
    fr_blank_pos = '0;
  endfunction

  // advance the predicted framer by one byte and return the output word
  function automatic frame_word_t frame_byte(input logic [7:0] b);
    frame_word_t         w;
    logic                done;
    logic                scan_blank;
    logic [LEN_BITS-1:0] digit;
    logic [LEN_BITS-1:0] len_max;
    logic [7:0]          blank_ch;
    w.out_byte    = b;
    w.message_end = 1'b0;
    done          = 1'b0;
    scan_blank    = 1'b1;
    len_max       = '1;
    case (fr_phase)
      PH_BODY: begin
        // body bytes are invisible to both matchers
        if (fr_remaining <= LEN_BITS'(1)) done = 1'b1;
        else fr_remaining = fr_remaining - LEN_BITS'(1);
        scan_blank = 1'b0;
      end
      PH_DIGITS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          digit = LEN_BITS'(b - CH_ZERO);
          // saturate instead of wrapping
          if (fr_remaining > (len_max - digit) / LEN_BITS'(10)) fr_remaining = len_max;
          else fr_remaining = fr_remaining * LEN_BITS'(10) + digit;
          scan_blank = 1'b0;
        end else begin
          // the terminating byte still goes to the blank line matcher
          fr_phase = PH_KNOWN;
        end
      end
      PH_HEADERS: begin
        // naive restart: a failing byte is not retried as the first char
        if (fr_hdr_pos < HDR_LEN && b == HDR_TEXT[8*(HDR_LEN-1-fr_hdr_pos) +: 8]) begin
          fr_hdr_pos = fr_hdr_pos + 5'd1;
          if (fr_hdr_pos == HDR_LEN) begin
            fr_phase     = PH_DIGITS;
            fr_remaining = '0;
          end
        end else begin
          fr_hdr_pos = '0;
        end
      end
      default: ;
    endcase
    if (scan_blank) begin
      blank_ch = fr_blank_pos[0] ? CH_LF : CH_CR;
      if (b == blank_ch) begin
        if (fr_blank_pos == 2'd3) begin
          fr_blank_pos = '0;
          if (fr_remaining != '0) fr_phase = PH_BODY;
          else done = 1'b1;
        end else begin
          fr_blank_pos = fr_blank_pos + 2'd1;
        end
      end else begin
        fr_blank_pos = '0;
      end
    end
    if (done) begin
      w.message_end = 1'b1;
      clear_framer();
    end
    return w;
  endfunction

  // output side: check every accepted word, then pick the next stall value
  always @(posedge clk) begin
    frame_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word, got out_byte %h message_end %b",
                 $time, out_byte, message_end);
        mismatch_count++;
      end else begin
        want = frames_due.pop_front();
        if (want.out_byte !== out_byte) begin
          $display("%0t: out_byte mismatch, expected %h actual %h",
                   $time, want.out_byte, out_byte);
          mismatch_count++;
        end
        if (want.message_end !== message_end) begin
          $display("%0t: message_end mismatch, expected %b actual %b",
                   $time, want.message_end, message_end);
          mismatch_count++;
        end
      end
    end
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // send one word, with a random idle gap first; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    // accepted at this edge
    frames_due.insert(frames_due.size(), frame_byte(b));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // sender holds off until every predicted word has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // no length header at all: the blank line ends the message
  task automatic test_no_length_header();
    send_text("HTTP/1.1 200 OK\r\nServer: x\r\n\r\n");
  endtask

  // explicit zero length and the missing digits case both end at the blank line
  task automatic test_zero_length();
    send_text("\r\nContent-Length: 0\r\n\r\n");
    send_text("\r\nContent-Length: \r\n\r\n");
  endtask

  // body carries the extreme byte values and CR LF, none of which may match
  task automatic test_body_extremes();
    send_text("\r\nContent-Length: 6\r\n\r\n");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // doubled CR breaks both matchers without a retry of the failing byte
  task automatic test_naive_restart();
    send_text("\r\r\nContent-Length: 3\r\r\n\r\n");
    send_text("\r\nContent-Len\r\nContent-Length: 1\r\n\r\nz");
  endtask

  // the byte after the digits feeds the blank line matcher
  task automatic test_digit_terminator();
    send_text("\r\nContent-Length: 2\r\n\r\nab");
    send_text("\r\nContent-Length: 003x\r\n\r\nabc");
  endtask

  task automatic send_random_text(input int n, input int lo, input int hi);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(hi, lo)));
  endtask

  task automatic send_header_line();
    send_text("\r\n");
    send_random_text($urandom_range(8, 1), 8'h41, 8'h7a);
    send_text(": ");
    send_random_text($urandom_range(10, 1), 8'h20, 8'h7e);
  endtask

  // mostly well-formed responses with random content, plus noise and broken headers
  task automatic test_random_traffic(input int n_bytes);
    int start;
    int pick;
    int body_len;
    int n_hdr;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_text("HTTP/1.1 200 OK");
        n_hdr = $urandom_range(2);
        repeat (n_hdr) send_header_line();
        body_len = $urandom_range(40);
        if ($urandom_range(9) < 8) begin
          send_text("\r\nContent-Length: ");
          if ($urandom_range(9) == 0) send_text("00");
          if ($urandom_range(19) != 0) send_text($sformatf("%0d", body_len));
          else body_len = 0;
          if ($urandom_range(3) == 0) send_header_line();
        end else begin
          body_len = 0;
        end
        send_text("\r\n\r\n");
        send_random_text(body_len, 0, 255);
      end else if (pick < 90) begin
        send_random_text($urandom_range(12, 1), 0, 255);
      end else begin
        send_text("\r\nContent-Length");
        send_random_text($urandom_range(4, 1), 0, 255);
        send_text("\r\n\r\n");
      end
    end
  endtask

  // length beyond the counter saturates; the body then never ends, so this goes last
  task automatic test_length_saturation();
    send_text("\r\nContent-Length: 42949672961234\r\n\r\n");
    send_random_text(30, 0, 255);
  endtask

  initial begin
    clear_framer();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed cases with no idling on either side
    test_no_length_header();
    test_zero_length();
    test_body_extremes();
    test_naive_restart();
    test_digit_terminator();
    wait_for_drain();

    // random traffic: no idling, sender idle, receiver stalling, both
    idle_pct = 0;  stall_pct = 0;
    test_random_traffic(300);
    wait_for_drain();
    idle_pct = 55; stall_pct = 0;
    test_random_traffic(300);
    wait_for_drain();
    idle_pct = 0;  stall_pct = 55;
    test_random_traffic(300);
    wait_for_drain();
    idle_pct = 24; stall_pct = 24;
    test_random_traffic(300);
    test_length_saturation();

    // let everything in flight come out
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
